@@ design/ven_pkg.sv @@
// ----------------------------------------------------------------------------
// ven_pkg
// Shared types and constants for the vector euclidean norm block.
// ----------------------------------------------------------------------------
package ven_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int SUM_WIDTH    = 48;
  localparam int NORM_WIDTH   = 24;

  localparam int SQ_WIDTH       = 2 * SAMPLE_WIDTH;
  localparam int ACC_WIDTH      = ((SUM_WIDTH > SQ_WIDTH) ? SUM_WIDTH : SQ_WIDTH) + 1;
  localparam int ROOT_ITERS     = (SUM_WIDTH + 1) / 2;
  localparam int ROOT_PAD_WIDTH = 2 * ROOT_ITERS;
  localparam int REM_WIDTH      = ROOT_ITERS + 2;
  localparam int CNT_WIDTH      = $clog2(ROOT_ITERS + 1);
  localparam int ROOT_EXT_WIDTH = (ROOT_ITERS > NORM_WIDTH) ? ROOT_ITERS : NORM_WIDTH;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] element;
    logic                           last;
  } in_item_t;

  typedef struct packed {
    logic [NORM_WIDTH-1:0] norm;
    logic                  saturated;
  } out_item_t;

  typedef struct packed {
    logic square_en;
    logic accum_en;
    logic clear;
  } mac_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_ROOT_START,
    ST_ROOT_RUN
  } ven_state_t;

endpackage

@@ design/ven_mac.sv @@
// ----------------------------------------------------------------------------
// ven_mac
// Squares a sample magnitude and adds it to a saturating sum of squares.
// ----------------------------------------------------------------------------
module ven_mac
  import ven_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  mac_ctl_t                ctl,
  input  logic [SAMPLE_WIDTH-1:0] mag,
  output logic [SUM_WIDTH-1:0]    sum,
  output logic                    overflowed
);

  logic [SQ_WIDTH-1:0]  sq_r;
  logic [SUM_WIDTH-1:0] sum_r;
  logic                 ovf_r;
  logic [SQ_WIDTH-1:0]  product;
  logic [ACC_WIDTH-1:0] total;
  logic                 exceeds;

  assign product = SQ_WIDTH'(mag) * SQ_WIDTH'(mag);
  assign total   = ACC_WIDTH'(sum_r) + ACC_WIDTH'(sq_r);
  assign exceeds = |total[ACC_WIDTH-1:SUM_WIDTH];

  always_ff @(posedge clk) begin
    if (ctl.square_en) begin
      sq_r <= product;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      sum_r <= '0;
      ovf_r <= 1'b0;
    end else if (ctl.accum_en) begin
      if (exceeds) begin
        sum_r <= '1;
        ovf_r <= 1'b1;
      end else begin
        sum_r <= total[SUM_WIDTH-1:0];
      end
    end
  end

  assign sum        = sum_r;
  assign overflowed = ovf_r;

endmodule

@@ design/ven_isqrt.sv @@
// ----------------------------------------------------------------------------
// ven_isqrt
// Floor integer square root, one result bit per cycle by the bit-pair method.
// ----------------------------------------------------------------------------
module ven_isqrt
  import ven_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  go,
  input  logic [SUM_WIDTH-1:0]  operand,
  output logic                  busy,
  output logic                  done,
  output logic [ROOT_ITERS-1:0] root
);

  logic [CNT_WIDTH-1:0]      cnt_r;
  logic                      done_r;
  logic [ROOT_PAD_WIDTH-1:0] op_r;
  logic [REM_WIDTH-1:0]      rem_r;
  logic [ROOT_ITERS-1:0]     root_r;
  logic [REM_WIDTH-1:0]      rem_shift;
  logic [REM_WIDTH-1:0]      trial;
  logic                      fits;

  assign rem_shift = {rem_r[REM_WIDTH-3:0], op_r[ROOT_PAD_WIDTH-1 -: 2]};
  assign trial     = {root_r, 2'b01};
  assign fits      = rem_shift >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (go) begin
      cnt_r  <= CNT_WIDTH'(ROOT_ITERS);
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CNT_WIDTH'(1));
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      op_r   <= ROOT_PAD_WIDTH'(operand);
      rem_r  <= '0;
      root_r <= '0;
    end else if (cnt_r != '0) begin
      op_r   <= op_r << 2;
      rem_r  <= fits ? (rem_shift - trial) : rem_shift;
      root_r <= {root_r[ROOT_ITERS-2:0], fits};
    end
  end

  assign busy = (cnt_r != '0);
  assign done = done_r;
  assign root = root_r;

  a_done_after_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> cnt_r == '0)
    else $error("root done while iterations remain");

endmodule

@@ design/vector_euclidean_norm.sv @@
// ----------------------------------------------------------------------------
// vector_euclidean_norm
// Streaming euclidean norm: sum of squares of fixed-point samples, then floor
// square root on the last element of each vector.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. A non-final
// element keeps busy high through the square and accumulate states; the
// magnitude is taken at the accepting edge. A final element also holds busy
// through the root start and root run states, while the root unit produces
// one bit per cycle.
// The result appears on out_item with out_valid high for exactly one cycle,
// the first cycle busy is low again; the receiver must take it then.
// ----------------------------------------------------------------------------
module vector_euclidean_norm
  import ven_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_item_t  in_item,
  output logic      busy,
  output logic      out_valid,
  output out_item_t out_item
);

  ven_state_t state_r, state_nxt;

  logic [SAMPLE_WIDTH-1:0]   raw;
  logic [SAMPLE_WIDTH-1:0]   mag_r;
  logic                      last_r;
  logic                      sat_hold_r;
  logic                      out_valid_r;
  out_item_t                 out_item_r;
  mac_ctl_t                  mac_ctl;
  logic                      root_go;
  logic [SUM_WIDTH-1:0]      sum;
  logic                      overflowed;
  logic                      root_busy;
  logic                      root_done;
  logic [ROOT_ITERS-1:0]     root;
  logic [ROOT_EXT_WIDTH-1:0] root_ext;
  logic [NORM_WIDTH-1:0]     norm_clamped;
  logic                      accept;

  assign accept = start && (state_r == ST_IDLE);
  assign raw    = in_item.element;

  ven_mac u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (mac_ctl),
    .mag        (mag_r),
    .sum        (sum),
    .overflowed (overflowed)
  );

  ven_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (root_go),
    .operand (sum),
    .busy    (root_busy),
    .done    (root_done),
    .root    (root)
  );

  assign root_ext     = ROOT_EXT_WIDTH'(root);
  assign norm_clamped = (root_ext > ROOT_EXT_WIDTH'({NORM_WIDTH{1'b1}}))
                        ? {NORM_WIDTH{1'b1}} : root_ext[NORM_WIDTH-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_SQUARE;
      end
      ST_SQUARE:     state_nxt = ST_ACCUM;
      ST_ACCUM:      state_nxt = last_r ? ST_ROOT_START : ST_IDLE;
      ST_ROOT_START: state_nxt = ST_ROOT_RUN;
      ST_ROOT_RUN: begin
        if (root_done) state_nxt = ST_IDLE;
      end
      default:       state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mac_ctl = '0;
    root_go = 1'b0;
    case (state_r)
      ST_SQUARE:     mac_ctl.square_en = 1'b1;
      ST_ACCUM:      mac_ctl.accum_en  = 1'b1;
      ST_ROOT_START: begin
        root_go       = 1'b1;
        mac_ctl.clear = 1'b1;
      end
      default: begin
        mac_ctl = '0;
        root_go = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_ROOT_RUN) && root_done;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mag_r  <= raw[SAMPLE_WIDTH-1] ? (~raw + SAMPLE_WIDTH'(1)) : raw;
      last_r <= in_item.last;
    end
    if (state_r == ST_ROOT_START) begin
      sat_hold_r <= overflowed;
    end
    if ((state_r == ST_ROOT_RUN) && root_done) begin
      out_item_r.norm      <= norm_clamped;
      out_item_r.saturated <= sat_hold_r;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_accept_starts_square: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_SQUARE)
    else $error("accepted transaction did not start squaring");

  a_result_follows_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_ROOT_RUN) && $past(root_done))
    else $error("result strobe without finished root");

  a_root_idle_outside_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_SQUARE || state_r == ST_ACCUM) |-> !root_busy)
    else $error("root unit busy outside root phase");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");

endmodule
